// File: rtl/core/sqbc_pkg.sv
// Shared types and codes for the send queue batch completion unit.
// Used by the channel interfaces, the ring memory, the sequencer and the top level.
package sqbc_pkg;

  localparam int DEF_MAX_BATCH   = 64;
  localparam int DEF_QUEUE_DEPTH = 64;

  // Width of the count fields that travel on the ports and in status.
  localparam int COUNT_FIELD_W = 7;

  localparam logic [2:0] FUNC_ENQUEUE   = 3'd0;
  localparam logic [2:0] FUNC_BYTES     = 3'd1;
  localparam logic [2:0] FUNC_NOT_READY = 3'd2;
  localparam logic [2:0] FUNC_ERROR     = 3'd3;
  localparam logic [2:0] FUNC_CANCEL    = 3'd4;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_ANSWER = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [2:0] STATUS_DONE        = 3'd0;
  localparam logic [2:0] STATUS_STREAM_ERR  = 3'd1;
  localparam logic [2:0] STATUS_NO_PROGRESS = 3'd2;
  localparam logic [2:0] STATUS_CANCELED    = 3'd3;
  localparam logic [2:0] STATUS_QUEUE_FULL  = 3'd4;
  localparam logic [2:0] STATUS_ACCEPTED    = 3'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  send_tag;
    logic [31:0] send_length;
    logic [31:0] already_sent;
    logic [31:0] completion_bytes;
    logic [7:0]  error_number;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [7:0]               answer_tag;
    logic [31:0]              sent_total;
    logic [2:0]               status;
    logic [7:0]               error_cause;
    logic [COUNT_FIELD_W-1:0] batch_count;
    logic [31:0]              head_remaining;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] sent;
    logic [31:0] remaining;
  } entry_t;

  typedef struct packed {
    logic [COUNT_FIELD_W-1:0] entry_count;
    logic [COUNT_FIELD_W-1:0] in_flight;
  } seq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ISSUE,
    S_FINAL
  } seq_state_t;

endpackage

// File: rtl/core/sqbc_if.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on sqbc_pkg for the payload structs.
interface sqbc_cmd_if;
  import sqbc_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface sqbc_rsp_if;
  import sqbc_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/sqbc_ring.sv
// Ring storage of pending sends: one write port, one read port, registered read data.
// Depends on sqbc_pkg for the entry layout.
module sqbc_ring #(
  parameter int QUEUE_DEPTH = sqbc_pkg::DEF_QUEUE_DEPTH,
  parameter int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  sqbc_pkg::entry_t   wr_entry,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output sqbc_pkg::entry_t   rd_entry
);
  import sqbc_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    // Read data holds while no read is issued.
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/sqbc_seq.sv
// Sequencer: walks one ring entry per cycle unless stalled; keeps head, count, batch size.
// Depends on sqbc_pkg and the command interface; drives the ring and the result register.
module sqbc_seq #(
  parameter int MAX_BATCH   = sqbc_pkg::DEF_MAX_BATCH,
  parameter int QUEUE_DEPTH = sqbc_pkg::DEF_QUEUE_DEPTH,
  parameter int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  sqbc_cmd_if.sink              cmd,
  input  logic                  out_valid,
  input  logic                  out_ready,
  output logic                  push,
  output sqbc_pkg::rsp_t        push_word,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output sqbc_pkg::entry_t      wr_entry,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  sqbc_pkg::entry_t      rd_entry,
  output sqbc_pkg::seq_status_t status
);
  import sqbc_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  seq_state_t state, state_next;

  logic [2:0]       op_func;
  logic [31:0]      op_bytes;
  logic [7:0]       op_cause;

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] in_flight;
  logic [CNT_W-1:0] walk_left;
  logic [CNT_W-1:0] issued;
  logic             walk_first;
  logic             held_valid;
  rsp_t             held;

  logic             cmd_fire;
  logic             out_free;
  logic             step;
  logic             queue_full;
  logic             walk_start;
  logic [SUM_W-1:0] slot_sum;
  logic [IDX_W-1:0] enq_slot;
  logic [IDX_W-1:0] head_inc;
  logic [31:0]      taken;
  logic [32:0]      sent_sum;
  logic [31:0]      new_sent;
  logic             partial;
  logic             no_prog;
  logic             has_res;
  logic             walk_end;
  logic             need_issue;
  logic [CNT_W-1:0] batch_size;
  rsp_t             walk_res;
  rsp_t             ack_word;

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign out_free   = !out_valid || out_ready;
  assign step       = (state == S_WALK) && (!held_valid || out_free);
  assign queue_full = (32'(count) >= QUEUE_DEPTH);

  assign slot_sum = SUM_W'(head) + SUM_W'(count);
  assign enq_slot = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    IDX_W'(slot_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(slot_sum);
  assign head_inc = (32'(head) == QUEUE_DEPTH - 1) ? '0 : head + 1'b1;

  // Walk starts when the command has entries to answer.
  always_comb begin
    case (cmd.data.func)
      FUNC_BYTES, FUNC_ERROR: walk_start = (in_flight != '0);
      FUNC_CANCEL:            walk_start = (count != '0);
      default:                walk_start = 1'b0;
    endcase
  end

  always_comb begin
    ack_word            = '0;
    ack_word.kind       = KIND_ACK;
    ack_word.answer_tag = cmd.data.send_tag;
    ack_word.sent_total = cmd.data.already_sent;
    ack_word.status     = queue_full ? STATUS_QUEUE_FULL : STATUS_ACCEPTED;
  end

  // Byte spreading for the entry whose read data is present.
  assign taken    = (op_bytes < rd_entry.remaining) ? op_bytes : rd_entry.remaining;
  assign sent_sum = {1'b0, rd_entry.sent} + {1'b0, taken};
  assign new_sent = sent_sum[32] ? '1 : sent_sum[31:0];
  assign partial  = (taken != rd_entry.remaining);
  assign no_prog  = walk_first && (op_bytes == '0) && (rd_entry.remaining != '0);

  always_comb begin
    walk_res             = '0;
    walk_res.kind        = KIND_ANSWER;
    walk_res.answer_tag  = rd_entry.tag;
    has_res              = 1'b1;
    walk_end             = (walk_left == CNT_W'(1));
    case (op_func)
      FUNC_BYTES: begin
        if (no_prog) begin
          walk_res.sent_total = rd_entry.sent;
          walk_res.status     = STATUS_NO_PROGRESS;
          walk_end            = 1'b1;
        end else begin
          walk_res.sent_total = new_sent;
          walk_res.status     = STATUS_DONE;
          has_res             = !partial;
          walk_end            = partial || (walk_left == CNT_W'(1));
        end
      end
      FUNC_ERROR: begin
        walk_res.sent_total  = rd_entry.sent;
        walk_res.status      = STATUS_STREAM_ERR;
        walk_res.error_cause = op_cause;
      end
      default: begin
        walk_res.status = STATUS_CANCELED;
      end
    endcase
  end

  assign need_issue = (in_flight == '0) && (count != '0);
  assign batch_size = (32'(count) < MAX_BATCH) ? count : CNT_W'(MAX_BATCH);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          state_next = walk_start ? S_WALK : S_ISSUE;
        end
      end
      S_WALK: begin
        if (step && walk_end) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: state_next = S_FINAL;
      S_FINAL: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs to the ring and the result register.
  always_comb begin
    push      = 1'b0;
    push_word = held;
    wr_en     = 1'b0;
    wr_addr   = head;
    wr_entry  = '0;
    rd_en     = 1'b0;
    rd_addr   = head;
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          if (cmd.data.func == FUNC_ENQUEUE && !queue_full) begin
            wr_en              = 1'b1;
            wr_addr            = enq_slot;
            wr_entry.tag       = cmd.data.send_tag;
            wr_entry.sent      = cmd.data.already_sent;
            wr_entry.remaining = cmd.data.send_length;
          end
          rd_en = walk_start;
        end
      end
      S_WALK: begin
        if (step) begin
          if (op_func == FUNC_BYTES && !no_prog && partial) begin
            // The send where the count stops keeps its remainder at the head.
            wr_en              = 1'b1;
            wr_entry.tag       = rd_entry.tag;
            wr_entry.sent      = new_sent;
            wr_entry.remaining = rd_entry.remaining - taken;
          end
          push    = has_res && held_valid;
          rd_en   = !walk_end;
          rd_addr = head_inc;
        end
      end
      S_ISSUE: begin
        rd_en = need_issue;
      end
      S_FINAL: begin
        push = out_free;
        if (!held_valid) begin
          push_word      = '0;
          push_word.kind = KIND_NONE;
        end
        push_word.last           = 1'b1;
        push_word.batch_count    = COUNT_FIELD_W'(issued);
        push_word.head_remaining = (issued != '0) ? rd_entry.remaining : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      in_flight  <= '0;
      issued     <= '0;
      held_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            op_func    <= cmd.data.func;
            op_bytes   <= cmd.data.completion_bytes;
            op_cause   <= cmd.data.error_number;
            walk_first <= 1'b1;
            walk_left  <= (cmd.data.func == FUNC_CANCEL) ? count : in_flight;
            issued     <= '0;
            case (cmd.data.func)
              FUNC_ENQUEUE: begin
                held_valid <= 1'b1;
                held       <= ack_word;
                if (!queue_full) begin
                  count <= count + 1'b1;
                end
              end
              // Every completion and a cancel end the outstanding batch.
              FUNC_BYTES, FUNC_NOT_READY, FUNC_ERROR, FUNC_CANCEL: in_flight <= '0;
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (step) begin
            walk_first <= 1'b0;
            walk_left  <= walk_left - 1'b1;
            if (op_func == FUNC_BYTES && !no_prog) begin
              op_bytes <= op_bytes - taken;
            end
            if (has_res) begin
              held_valid <= 1'b1;
              held       <= walk_res;
              head       <= head_inc;
              count      <= count - 1'b1;
            end
          end
        end
        S_ISSUE: begin
          if (need_issue) begin
            issued    <= batch_size;
            in_flight <= batch_size;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            held_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign status.entry_count = COUNT_FIELD_W'(count);
  assign status.in_flight   = COUNT_FIELD_W'(in_flight);

endmodule

// File: rtl/core/send_queue_batch_completion_unit.sv
// Send queue with batched completion: one command word at a time, one or more result words.
// Enqueue, not-ready and idle completions pass through the issue state to the final state,
// which registers their last result; a byte, error or cancel command first walks the
// ring entries it answers one at a time (up to 64), set by the single ring read port. Result
// stalls hold the walk and the final state; the next command is taken once its last result
// is registered. Reset clears head, count and batch state; ring contents stay undefined.
module send_queue_batch_completion_unit #(
  parameter int MAX_BATCH   = sqbc_pkg::DEF_MAX_BATCH,
  parameter int QUEUE_DEPTH = sqbc_pkg::DEF_QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  sqbc_cmd_if.sink   cmd,
  sqbc_rsp_if.source rsp
);
  import sqbc_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             push;
  rsp_t             push_word;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_entry;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;
  seq_status_t      status;

  sqbc_ring #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_entry(wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_entry(rd_entry)
  );

  sqbc_seq #(
    .MAX_BATCH  (MAX_BATCH),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .push     (push),
    .push_word(push_word),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .status   (status)
  );

  // Result register: the sequencer only pushes when it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (push) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp.data <= push_word;
    end
  end

  a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("command accepted while the previous one is still in work");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (status.in_flight <= status.entry_count) && (32'(status.entry_count) <= QUEUE_DEPTH))
    else $error("batch size or queue count out of range");

  a_batch_only_on_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.last |-> (rsp.data.batch_count == '0)
                                    && (rsp.data.head_remaining == '0))
    else $error("batch fields set on a result that is not the last");

  a_batch_limit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.last |-> 32'(rsp.data.batch_count) <= MAX_BATCH)
    else $error("issued batch larger than the batch limit");

endmodule

// File: tb/send_queue_batch_completion_unit_tb.sv
// Self-checking testbench for the send queue batch completion unit: directed rows, then random
// command traffic with idling and backpressure, every result word checked against a predictor.
// Depends on sqbc_pkg, the sqbc channel interfaces and the send_queue_batch_completion_unit RTL.
module send_queue_batch_completion_unit_tb;
  import sqbc_pkg::*;

  localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int MAX_BATCH = DEF_MAX_BATCH;
  localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS = 240;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    cmd_t cmd;
    bit   fixed;
    rsp_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  sqbc_cmd_if cmd_ch();
  sqbc_rsp_if rsp_ch();

  send_queue_batch_completion_unit dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  // Predictor copy of the send ring.
  logic [31:0] ring_remaining [QUEUE_DEPTH];
  logic [31:0] ring_sent [QUEUE_DEPTH];
  logic [7:0]  ring_tag [QUEUE_DEPTH];
  int ring_head;
  int ring_count;
  int batch_size;

  rsp_t run_words[$];
  rsp_t pending_answers[$];
  rsp_t oldest_answer;
  stim_row_t directed_rows[$];

  int mismatch_count;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic rsp_t result_word(logic [1:0] kind, logic [7:0] tag, logic [31:0] bytes,
                                       logic [2:0] status, logic [7:0] cause,
                                       logic [6:0] issued, logic [31:0] head_left, logic last);
    rsp_t w;
    w.kind = kind;
    w.answer_tag = tag;
    w.sent_total = bytes;
    w.status = status;
    w.error_cause = cause;
    w.batch_count = issued;
    w.head_remaining = head_left;
    w.last = last;
    return w;
  endfunction

  function automatic stim_row_t stim_row(logic [2:0] func, logic [7:0] tag, logic [31:0] len,
                                         logic [31:0] sent, logic [31:0] bytes,
                                         logic [7:0] errno, bit fixed, rsp_t want);
    stim_row_t r;
    r.cmd.func = func;
    r.cmd.send_tag = tag;
    r.cmd.send_length = len;
    r.cmd.already_sent = sent;
    r.cmd.completion_bytes = bytes;
    r.cmd.error_number = errno;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  task automatic drop_front(input int n);
    ring_head = (ring_head + n) % QUEUE_DEPTH;
    ring_count = ring_count - n;
  endtask

  // Computes the result words that one command causes and updates the ring copy.
  task automatic predict_answers(input cmd_t c);
    logic [31:0] left;
    logic [31:0] size;
    logic [31:0] take;
    logic [32:0] total;
    logic [6:0]  issued;
    logic [31:0] head_left;
    int done;
    int slot;
    int i;
    rsp_t w;
    issued = '0;
    head_left = '0;
    left = c.completion_bytes;
    run_words.delete();
    case (c.func)
      FUNC_ENQUEUE: begin
        if (ring_count >= QUEUE_DEPTH) begin
          run_words.push_back(result_word(KIND_ACK, c.send_tag, c.already_sent,
                                          STATUS_QUEUE_FULL, '0, '0, '0, 1'b0));
        end else begin
          slot = (ring_head + ring_count) % QUEUE_DEPTH;
          ring_remaining[slot] = c.send_length;
          ring_sent[slot] = c.already_sent;
          ring_tag[slot] = c.send_tag;
          ring_count++;
          run_words.push_back(result_word(KIND_ACK, c.send_tag, c.already_sent,
                                          STATUS_ACCEPTED, '0, '0, '0, 1'b0));
        end
      end
      FUNC_BYTES: begin
        if (batch_size != 0) begin
          slot = ring_head;
          if (left == 0 && ring_remaining[slot] != 0) begin
            run_words.push_back(result_word(KIND_ANSWER, ring_tag[slot], ring_sent[slot],
                                            STATUS_NO_PROGRESS, '0, '0, '0, 1'b0));
            drop_front(1);
          end else begin
            done = 0;
            for (i = 0; i < batch_size; i++) begin
              slot = (ring_head + i) % QUEUE_DEPTH;
              size = ring_remaining[slot];
              take = (left < size) ? left : size;
              total = {1'b0, ring_sent[slot]} + {1'b0, take};
              ring_sent[slot] = total[32] ? 32'hFFFF_FFFF : total[31:0];
              left = left - take;
              if (take == size) begin
                ring_remaining[slot] = '0;
                run_words.push_back(result_word(KIND_ANSWER, ring_tag[slot], ring_sent[slot],
                                                STATUS_DONE, '0, '0, '0, 1'b0));
                done++;
              end else begin
                ring_remaining[slot] = size - take;
                break;
              end
            end
            drop_front(done);
          end
          batch_size = 0;
        end
      end
      FUNC_NOT_READY: batch_size = 0;
      FUNC_ERROR: begin
        if (batch_size != 0) begin
          for (i = 0; i < batch_size; i++) begin
            slot = (ring_head + i) % QUEUE_DEPTH;
            run_words.push_back(result_word(KIND_ANSWER, ring_tag[slot], ring_sent[slot],
                                            STATUS_STREAM_ERR, c.error_number, '0, '0, 1'b0));
          end
          drop_front(batch_size);
          batch_size = 0;
        end
      end
      FUNC_CANCEL: begin
        for (i = 0; i < ring_count; i++) begin
          slot = (ring_head + i) % QUEUE_DEPTH;
          run_words.push_back(result_word(KIND_ANSWER, ring_tag[slot], '0,
                                          STATUS_CANCELED, '0, '0, '0, 1'b0));
        end
        drop_front(ring_count);
        batch_size = 0;
      end
      default: ;
    endcase
    if (batch_size == 0 && ring_count != 0) begin
      batch_size = (ring_count < MAX_BATCH) ? ring_count : MAX_BATCH;
      issued = batch_size[6:0];
      head_left = ring_remaining[ring_head];
    end
    if (run_words.size() == 0)
      run_words.push_back(result_word(KIND_NONE, '0, '0, STATUS_DONE, '0, '0, '0, 1'b0));
    w = run_words[run_words.size() - 1];
    w.batch_count = issued;
    w.head_remaining = head_left;
    w.last = 1'b1;
    run_words[run_words.size() - 1] = w;
  endtask

  // Offers one command word, then records what it should cause once it is taken.
  task automatic send_word(input cmd_t c, input bit fixed, input rsp_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= c;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predict_answers(c);
    if (fixed)
      pending_answers.push_back(want);
    else
      foreach (run_words[k]) pending_answers.push_back(run_words[k]);
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    int k;
    int i;
    logic [63:0] total;
    c.func = FUNC_ENQUEUE;
    c.send_tag = 8'($urandom);
    c.send_length = $urandom;
    c.already_sent = $urandom;
    c.completion_bytes = $urandom;
    c.error_number = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(3))
        0: c.send_length = '0;
        1: c.send_length = $urandom_range(1, 64);
        2: c.send_length = $urandom_range(65, 4096);
        default: ;
      endcase
      case ($urandom_range(7))
        0: c.already_sent = 32'hFFFF_FFFF - $urandom_range(0, 200);
        1: ;
        default: c.already_sent = $urandom_range(0, 5000);
      endcase
    end else if (pick < 75) begin
      c.func = FUNC_BYTES;
      // Aim the byte count at the boundaries between the sends of the batch.
      total = '0;
      k = $urandom_range(0, batch_size);
      for (i = 0; i < k; i++)
        total = total + 64'(ring_remaining[(ring_head + i) % QUEUE_DEPTH]);
      case ($urandom_range(7))
        0: total = '0;
        1: total = total + 64'd1;
        2: if (total != 0) total = total - 64'd1;
        3: total = {32'd0, c.completion_bytes};
        4: total = 64'hFFFF_FFFF;
        default: ;
      endcase
      c.completion_bytes = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    end else if (pick < 83) begin
      c.func = FUNC_NOT_READY;
    end else if (pick < 92) begin
      c.func = FUNC_ERROR;
    end else if (pick < 96) begin
      c.func = FUNC_CANCEL;
    end else begin
      c.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
    end
    return c;
  endfunction

  // Fills the ring to capacity, pushes two more that must be refused, then closes with a
  // command that answers the whole ring at once.
  task automatic fill_queue_then(input logic [2:0] closing_func);
    cmd_t c;
    int extra;
    extra = 0;
    while (ring_count < QUEUE_DEPTH || extra < 2) begin
      if (ring_count >= QUEUE_DEPTH) extra++;
      c = random_cmd();
      c.func = FUNC_ENQUEUE;
      c.send_length = $urandom_range(0, 300);
      send_word(c, 1'b0, '0);
      items_sent++;
    end
    c = random_cmd();
    if (closing_func == FUNC_ERROR) begin
      // A not-ready first reissues the batch so that it covers all 64 sends.
      c.func = FUNC_NOT_READY;
      send_word(c, 1'b0, '0);
      items_sent++;
    end
    c.func = closing_func;
    send_word(c, 1'b0, '0);
    items_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, actual %p",
                 $time, rsp_ch.data);
        mismatch_count++;
      end else begin
        oldest_answer = pending_answers[0];
        pending_answers.delete(0);
        check_field("kind", 32'(oldest_answer.kind), 32'(rsp_ch.data.kind));
        check_field("answer_tag", 32'(oldest_answer.answer_tag), 32'(rsp_ch.data.answer_tag));
        check_field("sent_total", oldest_answer.sent_total, rsp_ch.data.sent_total);
        check_field("status", 32'(oldest_answer.status), 32'(rsp_ch.data.status));
        check_field("error_cause", 32'(oldest_answer.error_cause),
                    32'(rsp_ch.data.error_cause));
        check_field("batch_count", 32'(oldest_answer.batch_count),
                    32'(rsp_ch.data.batch_count));
        check_field("head_remaining", oldest_answer.head_remaining,
                    rsp_ch.data.head_remaining);
        check_field("last", 32'(oldest_answer.last), 32'(rsp_ch.data.last));
      end
    end
  end

  // Receiver: random ready, with a long hold-off each time the stimulus asks for it.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          rsp_ch.ready <= 1'b0;
          @(negedge clk);
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rsp_t none_word;
    cmd_t c;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    mismatch_count = 0;
    hold_request = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 51;
    items_sent = 0;
    ring_head = 0;
    ring_count = 0;
    batch_size = 0;
    none_word = result_word(KIND_NONE, '0, '0, STATUS_DONE, '0, '0, '0, 1'b1);

    // Idle completions and unused codes answer only with a none word; then the field extremes.
    directed_rows.push_back(stim_row(FUNC_BYTES, 8'h00, '0, '0, 32'hFFFF_FFFF, '0, 1'b1,
        none_word));
    directed_rows.push_back(stim_row(FUNC_NOT_READY, 8'h00, '0, '0, '0, '0, 1'b1, none_word));
    directed_rows.push_back(stim_row(FUNC_ERROR, 8'h00, '0, '0, '0, 8'hFF, 1'b1, none_word));
    directed_rows.push_back(stim_row(FUNC_CANCEL, 8'h00, '0, '0, '0, '0, 1'b1, none_word));
    directed_rows.push_back(stim_row(FUNC_UNUSED_LO, 8'hFF, '1, '1, '1, 8'hFF, 1'b1, none_word));
    directed_rows.push_back(stim_row(FUNC_UNUSED_HI, 8'h00, '0, '0, '0, '0, 1'b1, none_word));
    directed_rows.push_back(stim_row(FUNC_ENQUEUE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0,
        1'b1, result_word(KIND_ACK, 8'hFF, 32'hFFFF_FFFF, STATUS_ACCEPTED, '0, 7'd1,
                          32'hFFFF_FFFF, 1'b1)));
    // The byte total saturates instead of wrapping.
    directed_rows.push_back(stim_row(FUNC_BYTES, '0, '0, '0, 32'hFFFF_FFFF, '0, 1'b1,
        result_word(KIND_ANSWER, 8'hFF, 32'hFFFF_FFFF, STATUS_DONE, '0, '0, '0, 1'b1)));
    // A zero-length send is finished by a zero byte completion.
    directed_rows.push_back(stim_row(FUNC_ENQUEUE, 8'h00, 32'd0, 32'd10, '0, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_ENQUEUE, 8'h02, 32'd100, 32'd0, '0, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_BYTES, '0, '0, '0, 32'd0, '0, 1'b0, '0));
    // Zero bytes while the head still has bytes left fails only the head send.
    directed_rows.push_back(stim_row(FUNC_BYTES, '0, '0, '0, 32'd0, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_ENQUEUE, 8'h03, 32'd50, 32'd7, '0, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_ENQUEUE, 8'h04, 32'd30, 32'd0, '0, '0, 1'b0, '0));
    // Partial coverage keeps the remainder at the head, then surplus bytes are dropped.
    directed_rows.push_back(stim_row(FUNC_BYTES, '0, '0, '0, 32'd20, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_BYTES, '0, '0, '0, 32'd1000, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_ENQUEUE, 8'h05, 32'd10, 32'd1, '0, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_ENQUEUE, 8'h06, 32'd20, 32'd2, '0, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_NOT_READY, '0, '0, '0, '0, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_ERROR, '0, '0, '0, '0, 8'hA5, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_ENQUEUE, 8'h07, 32'd5, 32'd0, '0, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_ENQUEUE, 8'h08, 32'd6, 32'd0, '0, '0, 1'b0, '0));
    directed_rows.push_back(stim_row(FUNC_CANCEL, '0, '0, '0, '0, '0, 1'b0, '0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_word(directed_rows[r].cmd, directed_rows[r].fixed, directed_rows[r].want);

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= 180) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= 90) begin
        send_idle_pct = 51;
        recv_idle_pct = 38;
      end
      if (items_sent == 40) begin
        hold_request = 1'b1;
        items_sent++;
        c = random_cmd();
        c.func = FUNC_ENQUEUE;
        send_word(c, 1'b0, '0);
      end else if (items_sent == 70) begin
        fill_queue_then(FUNC_ERROR);
      end else if (items_sent == 150) begin
        // The sender waits here until every outstanding result word has come back.
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        items_sent++;
      end else if (items_sent == 200) begin
        hold_request = 1'b1;
        fill_queue_then(FUNC_CANCEL);
      end else begin
        c = random_cmd();
        send_word(c, 1'b0, '0);
        if (c.func < FUNC_UNUSED_LO) items_sent++;
      end
    end

    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
